// ----- rtl/core/bim_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the backtrackable index map.
// No dependencies; imported by every module of the block.
package bim_pkg;

	// Stream payload widths (fields packed from bit 0, padded to bytes)
	localparam int IN_TDATA_W  = 48;
	localparam int OUT_TDATA_W = 40;
	localparam int KEY_W       = 10;
	localparam int VAL_W       = 32;

	// Generation tag kept next to each table value; a saved bit is set
	// when the tag equals the current generation
	localparam int GEN_W = 16;

	localparam logic [VAL_W-1:0] NIL_VALUE = '1;

	typedef enum logic [2:0] {
		OP_GET   = 3'd0,
		OP_SET   = 3'd1,
		OP_MAP   = 3'd2,
		OP_REMAP = 3'd3,
		OP_PUSH  = 3'd4,
		OP_POP   = 3'd5
	} opcode_t;

	typedef enum logic [1:0] {
		STAT_OK      = 2'd0,
		STAT_RANGE   = 2'd1,
		STAT_FULL    = 2'd2,
		STAT_PRECOND = 2'd3
	} status_t;

	// One table word: value plus generation tag
	typedef struct packed {
		logic [GEN_W-1:0] tag;
		logic [VAL_W-1:0] val;
	} tbl_word_t;

	// Table write enables, one per field of the word
	typedef struct packed {
		logic we_val;
		logic we_tag;
	} tbl_wr_t;

endpackage

// ----- rtl/core/backtrackable_index_map_unit.sv -----
`timescale 1ns / 1ps
// Backtrackable index map top level: control sequencer and output register.
// Depends on bim_pkg, bim_table_ram and bim_trail_ram.
//
// Usage: items arrive on s_tvalid/s_tready/s_tdata (opcode, key, new_value),
// one result item leaves per input item on m_tvalid/m_tready/m_tdata
// (read_value, status). One item is worked on at a time; s_tready is high
// only while the sequencer is idle.
// Steps per item:
//   get, set mark, map, remap without logging, push, errors: table read on
//   acceptance, then write-back and result in the execute step.
//   logging remap: result loaded in the execute step; the second trail write
//   (the old value) follows before the next item is taken.
//   pop: undo walk over the top frame, read of the enclosing frame base, then
//   rebuild walk over the keys logged in the enclosing frame, then the result;
//   both walks share the single trail read port.
//   Every 65535th push or pop also sweeps the tag field of the table before
//   its result leaves.
// Reset: a clearing pass writes nil into every table
// entry; s_tready stays low until it ends.
// Stall: the result sits in an output register; the next result waits in
// the item's last step, writing nothing more, until that register is free.
module backtrackable_index_map_unit
	import bim_pkg::*;
#(
	parameter int TABLE_DEPTH = 1024,
	parameter int TRAIL_DEPTH = 4096
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// [2:0] opcode, [12:3] key, [44:13] new_value, [47:45] zero
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// [31:0] read_value, [33:32] status, [39:34] zero
	output logic [OUT_TDATA_W-1:0] m_tdata
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int TA = $clog2(TRAIL_DEPTH);
	localparam int TW = $clog2(TRAIL_DEPTH + 1);
	localparam int IW = TW + 1;

	typedef enum logic [3:0] {
		S_INIT,
		S_IDLE,
		S_EXEC,
		S_REMAP2,
		S_UNDO_RD,
		S_UNDO_DAT,
		S_UNDO_OLD,
		S_PARENT,
		S_TAGCLR,
		S_RB_RD,
		S_RB_DAT,
		S_FINISH
	} state_t;

	state_t           state_q;
	opcode_t          op_q;
	logic [KEY_W-1:0] key_q;
	logic [VAL_W-1:0] val_q;
	logic [VAL_W-1:0] old_q;
	logic [AW-1:0]    sweep_q;
	logic [AW-1:0]    kept_q;
	logic [TW-1:0]    top_q;
	logic [TW-1:0]    level_q;
	logic [TA-1:0]    fb_q;
	logic             fb_valid_q;
	logic [IW-1:0]    i_q;
	logic             rb_en_q;
	logic [GEN_W-1:0] gen_q;
	logic             m_tvalid_q;
	logic [VAL_W-1:0] out_val_q;
	status_t          out_st_q;

	// Memory ports
	logic             tbl_rd_en;
	logic [AW-1:0]    tbl_rd_addr;
	tbl_word_t        tbl_rd_word;
	tbl_wr_t          tbl_wr;
	logic [AW-1:0]    tbl_wr_addr;
	logic [VAL_W-1:0] tbl_wr_val;
	logic [GEN_W-1:0] tbl_wr_tag;
	logic             trl_rd_en;
	logic [TA-1:0]    trl_rd_addr;
	logic [VAL_W-1:0] trl_rd_data;
	logic             trl_wr_en;
	logic [TA-1:0]    trl_wr_addr;
	logic [VAL_W-1:0] trl_wr_data;

	bim_table_ram #(
		.DEPTH(TABLE_DEPTH),
		.AW   (AW)
	) u_table (
		.clk    (clk),
		.rd_en  (tbl_rd_en),
		.rd_addr(tbl_rd_addr),
		.rd_word(tbl_rd_word),
		.wr     (tbl_wr),
		.wr_addr(tbl_wr_addr),
		.wr_val (tbl_wr_val),
		.wr_tag (tbl_wr_tag)
	);

	bim_trail_ram #(
		.DEPTH(TRAIL_DEPTH),
		.AW   (TA)
	) u_trail (
		.clk    (clk),
		.rd_en  (trl_rd_en),
		.rd_addr(trl_rd_addr),
		.rd_data(trl_rd_data),
		.wr_en  (trl_wr_en),
		.wr_addr(trl_wr_addr),
		.wr_data(trl_wr_data)
	);

	// Handshake and shared terms
	logic             s_accept;
	logic             out_free;
	logic [VAL_W-1:0] s_key_ext;
	logic [VAL_W-1:0] key_ext;
	logic [VAL_W-1:0] fb_enc;
	logic [TW-1:0]    top_inc;
	logic [TW:0]      top_plus2;
	logic             full1;
	logic             full2;
	logic             in_frame;
	logic             gen_wrap;
	logic [IW-1:0]    i_inc1;
	logic [IW-1:0]    i_inc2;
	logic             i_lt_top;
	logic             i1_lt_top;
	logic             sweep_last;
	logic [VAL_W-1:0] trl_key;
	logic             trl_key_ok;

	assign s_tready   = (state_q == S_IDLE);
	assign s_accept   = s_tvalid && s_tready;
	assign out_free   = !m_tvalid_q || m_tready;
	assign s_key_ext  = VAL_W'(s_tdata[12:3]);
	assign key_ext    = VAL_W'(key_q);
	assign fb_enc     = fb_valid_q ? VAL_W'(fb_q) : NIL_VALUE;
	assign top_inc    = top_q + TW'(1);
	assign top_plus2  = {1'b0, top_q} + (TW+1)'(2);
	assign full1      = top_q >= TW'(TRAIL_DEPTH);
	assign full2      = top_plus2 > (TW+1)'(TRAIL_DEPTH);
	assign in_frame   = (level_q != '0);
	assign gen_wrap   = (gen_q == '1);
	assign i_inc1     = i_q + IW'(1);
	assign i_inc2     = i_q + IW'(2);
	assign i_lt_top   = i_q < {1'b0, top_q};
	assign i1_lt_top  = i_inc1 < {1'b0, top_q};
	assign sweep_last = (sweep_q == AW'(TABLE_DEPTH - 1));
	assign trl_key    = trl_rd_data[VAL_W-1] ? ~trl_rd_data : trl_rd_data;
	assign trl_key_ok = trl_key < VAL_W'(TABLE_DEPTH);

	// Item decode from the table word read for it
	logic             key_bad;
	logic             marked;
	logic [VAL_W-1:0] cur;
	status_t          ex_st;
	logic [VAL_W-1:0] ex_rd;
	logic             ex_wr_val;
	logic             ex_log;
	logic             ex_remap_log;
	logic             ex_push;
	logic             ex_pop;
	logic [VAL_W-1:0] ex_trail_data;

	assign key_bad = key_ext >= VAL_W'(TABLE_DEPTH);
	assign cur     = tbl_rd_word.val;
	assign marked  = in_frame && (tbl_rd_word.tag == gen_q);

	always_comb begin
		ex_st         = STAT_OK;
		ex_rd         = '0;
		ex_wr_val     = 1'b0;
		ex_log        = 1'b0;
		ex_remap_log  = 1'b0;
		ex_push       = 1'b0;
		ex_pop        = 1'b0;
		ex_trail_data = key_ext;
		if (key_bad && (op_q inside {OP_GET, OP_SET, OP_MAP, OP_REMAP})) begin
			ex_st = STAT_RANGE;
			ex_rd = (op_q == OP_GET) ? NIL_VALUE : '0;
		end else begin
			unique case (op_q)
				OP_GET: begin
					ex_rd = cur;
				end
				OP_SET: begin
					if (val_q[VAL_W-1] && (val_q != NIL_VALUE) && cur[VAL_W-1]) begin
						ex_wr_val = 1'b1;
					end else begin
						ex_st = STAT_PRECOND;
					end
				end
				OP_MAP: begin
					if (val_q[VAL_W-1] || !cur[VAL_W-1] || marked) begin
						ex_st = STAT_PRECOND;
					end else if (in_frame && full1) begin
						ex_st = STAT_FULL;
					end else begin
						ex_wr_val = 1'b1;
						ex_log    = in_frame;
					end
				end
				OP_REMAP: begin
					ex_trail_data = ~key_ext;
					if (val_q[VAL_W-1] || cur[VAL_W-1]) begin
						ex_st = STAT_PRECOND;
					end else if (in_frame && !marked) begin
						if (full2) begin
							ex_st = STAT_FULL;
						end else begin
							ex_wr_val    = 1'b1;
							ex_log       = 1'b1;
							ex_remap_log = 1'b1;
						end
					end else begin
						ex_wr_val = 1'b1;
					end
				end
				OP_PUSH: begin
					ex_trail_data = fb_enc;
					if (full1) begin
						ex_st = STAT_FULL;
					end else begin
						ex_push = 1'b1;
					end
				end
				OP_POP: begin
					if (!in_frame || !fb_valid_q || (TW'(fb_q) >= top_q)) begin
						ex_st = STAT_PRECOND;
					end else begin
						ex_pop = 1'b1;
					end
				end
				default: begin
					ex_st = STAT_PRECOND;
				end
			endcase
		end
	end

	// Result leaves from the execute step unless a walk or sweep follows
	logic ex_emit;
	logic out_load;

	assign ex_emit  = !(ex_pop || (ex_push && gen_wrap));
	assign out_load = out_free &&
		(((state_q == S_EXEC) && ex_emit) || (state_q == S_FINISH));

	// Memory port control
	always_comb begin
		tbl_rd_en   = 1'b0;
		tbl_rd_addr = s_key_ext[AW-1:0];
		tbl_wr      = '0;
		tbl_wr_addr = key_ext[AW-1:0];
		tbl_wr_val  = val_q;
		tbl_wr_tag  = gen_q;
		trl_rd_en   = 1'b0;
		trl_rd_addr = i_q[TA-1:0];
		trl_wr_en   = 1'b0;
		trl_wr_addr = top_q[TA-1:0];
		trl_wr_data = ex_trail_data;
		unique case (state_q)
			S_INIT: begin
				tbl_wr      = '{we_val: 1'b1, we_tag: 1'b1};
				tbl_wr_addr = sweep_q;
				tbl_wr_val  = NIL_VALUE;
				tbl_wr_tag  = '0;
			end
			S_IDLE: begin
				tbl_rd_en = s_accept;
			end
			S_EXEC: begin
				if (out_free) begin
					tbl_wr    = '{we_val: ex_wr_val, we_tag: ex_log};
					trl_wr_en = ex_log || ex_push;
				end
			end
			S_REMAP2: begin
				trl_wr_en   = 1'b1;
				trl_wr_addr = top_inc[TA-1:0];
				trl_wr_data = old_q;
			end
			S_UNDO_RD: begin
				trl_rd_en = 1'b1;
				if (!i_lt_top) begin
					trl_rd_addr = fb_q;
				end
			end
			S_UNDO_DAT: begin
				if (trl_rd_data[VAL_W-1]) begin
					trl_rd_en   = i1_lt_top && trl_key_ok;
					trl_rd_addr = i_inc1[TA-1:0];
				end else begin
					tbl_wr.we_val = trl_key_ok;
					tbl_wr_addr   = trl_key[AW-1:0];
					tbl_wr_val    = NIL_VALUE;
				end
			end
			S_UNDO_OLD: begin
				tbl_wr.we_val = 1'b1;
				tbl_wr_addr   = kept_q;
				tbl_wr_val    = trl_rd_data;
			end
			S_TAGCLR: begin
				tbl_wr.we_tag = 1'b1;
				tbl_wr_addr   = sweep_q;
				tbl_wr_tag    = '0;
			end
			S_RB_RD: begin
				trl_rd_en = rb_en_q && i_lt_top;
			end
			S_RB_DAT: begin
				tbl_wr.we_tag = trl_key_ok;
				tbl_wr_addr   = trl_key[AW-1:0];
			end
			S_PARENT, S_FINISH: begin
			end
			default: begin
			end
		endcase
	end

	// Sequencer, trail pointers and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_INIT;
			op_q       <= OP_GET;
			key_q      <= '0;
			val_q      <= '0;
			old_q      <= '0;
			sweep_q    <= '0;
			kept_q     <= '0;
			top_q      <= '0;
			level_q    <= '0;
			fb_q       <= '0;
			fb_valid_q <= 1'b0;
			i_q        <= '0;
			rb_en_q    <= 1'b0;
			gen_q      <= GEN_W'(1);
			m_tvalid_q <= 1'b0;
			out_val_q  <= '0;
			out_st_q   <= STAT_OK;
		end else begin
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_INIT: begin
					sweep_q <= sweep_q + AW'(1);
					if (sweep_last) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (s_accept) begin
						op_q    <= opcode_t'(s_tdata[2:0]);
						key_q   <= s_tdata[12:3];
						val_q   <= s_tdata[44:13];
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (out_free) begin
						old_q <= cur;
						if (ex_emit) begin
							out_val_q <= ex_rd;
							out_st_q  <= ex_st;
						end
						if (ex_log && !ex_remap_log) begin
							top_q <= top_inc;
						end
						if (ex_remap_log) begin
							state_q <= S_REMAP2;
						end else if (ex_push && gen_wrap) begin
							state_q <= S_TAGCLR;
						end else if (ex_pop) begin
							state_q <= S_UNDO_RD;
						end else begin
							state_q <= S_IDLE;
						end
						if (ex_push) begin
							fb_q       <= top_q[TA-1:0];
							fb_valid_q <= 1'b1;
							top_q      <= top_inc;
							level_q    <= level_q + TW'(1);
							rb_en_q    <= 1'b0;
							if (gen_wrap) begin
								gen_q   <= GEN_W'(1);
								sweep_q <= '0;
							end else begin
								gen_q <= gen_q + GEN_W'(1);
							end
						end
						if (ex_pop) begin
							i_q <= IW'(fb_q) + IW'(1);
						end
					end
				end
				S_REMAP2: begin
					top_q   <= top_plus2[TW-1:0];
					state_q <= S_IDLE;
				end
				S_UNDO_RD: begin
					state_q <= i_lt_top ? S_UNDO_DAT : S_PARENT;
				end
				S_UNDO_DAT: begin
					if (trl_rd_data[VAL_W-1]) begin
						kept_q <= trl_key[AW-1:0];
						if (i1_lt_top && trl_key_ok) begin
							state_q <= S_UNDO_OLD;
						end else begin
							i_q     <= i_inc2;
							state_q <= S_UNDO_RD;
						end
					end else begin
						i_q     <= i_inc1;
						state_q <= S_UNDO_RD;
					end
				end
				S_UNDO_OLD: begin
					i_q     <= i_inc2;
					state_q <= S_UNDO_RD;
				end
				S_PARENT: begin
					// trail word at the old frame base holds the enclosing base
					top_q      <= TW'(fb_q);
					fb_valid_q <= !trl_rd_data[VAL_W-1];
					fb_q       <= trl_rd_data[TA-1:0];
					level_q    <= level_q - TW'(1);
					i_q        <= IW'(trl_rd_data[TA-1:0]) + IW'(1);
					rb_en_q    <= (level_q != TW'(1)) && !trl_rd_data[VAL_W-1] &&
						(trl_rd_data < VAL_W'(fb_q));
					if (gen_wrap) begin
						gen_q   <= GEN_W'(1);
						sweep_q <= '0;
						state_q <= S_TAGCLR;
					end else begin
						gen_q   <= gen_q + GEN_W'(1);
						state_q <= S_RB_RD;
					end
				end
				S_TAGCLR: begin
					sweep_q <= sweep_q + AW'(1);
					if (sweep_last) begin
						state_q <= S_RB_RD;
					end
				end
				S_RB_RD: begin
					state_q <= (rb_en_q && i_lt_top) ? S_RB_DAT : S_FINISH;
				end
				S_RB_DAT: begin
					i_q     <= trl_rd_data[VAL_W-1] ? i_inc2 : i_inc1;
					state_q <= S_RB_RD;
				end
				S_FINISH: begin
					if (out_free) begin
						out_val_q <= '0;
						out_st_q  <= STAT_OK;
						state_q   <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {(OUT_TDATA_W - VAL_W - 2)'(0), out_st_q, out_val_q};

endmodule

// ----- rtl/core/bim_table_ram.sv -----
`timescale 1ns / 1ps
// Key table: value and generation tag per key, one read and one write port.
// Depends on bim_pkg for the word and write-enable types.
module bim_table_ram
	import bim_pkg::*;
#(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  logic             clk,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output tbl_word_t        rd_word,
	input  tbl_wr_t          wr,
	input  logic [AW-1:0]    wr_addr,
	input  logic [VAL_W-1:0] wr_val,
	input  logic [GEN_W-1:0] wr_tag
);

	tbl_word_t mem [DEPTH];

	// Field-wise write
	always_ff @(posedge clk) begin
		if (wr.we_val) begin
			mem[wr_addr].val <= wr_val;
		end
		if (wr.we_tag) begin
			mem[wr_addr].tag <= wr_tag;
		end
	end

	// Registered read, holds while idle
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_word <= mem[rd_addr];
		end
	end

endmodule

// ----- rtl/core/bim_trail_ram.sv -----
`timescale 1ns / 1ps
// Undo trail storage: 32-bit words, one read and one write port.
// Depends on bim_pkg for the word width.
module bim_trail_ram
	import bim_pkg::*;
#(
	parameter int DEPTH = 4096,
	parameter int AW    = 12
) (
	input  logic             clk,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [VAL_W-1:0] rd_data,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [VAL_W-1:0] wr_data
);

	logic [VAL_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ----- test/bim_checker.sv -----
`timescale 1ns / 1ps
// Checker for backtrackable_index_map_unit: follows the table, saved bits and undo trail,
// works out each result item and compares it with the output stream.
// Depends on bim_pkg.
module bim_checker
	import bim_pkg::*;
#(
	parameter int TABLE_DEPTH = 1024,
	parameter int TRAIL_DEPTH = 4096
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	input  logic                   s_tready,
	// [2:0] opcode, [12:3] key, [44:13] new_value, [47:45] zero
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	input  logic                   m_tvalid,
	input  logic                   m_tready,
	// [31:0] read_value, [33:32] status, [39:34] zero
	input  logic [OUT_TDATA_W-1:0] m_tdata,
	output int                     fail_count,
	output int                     pending,
	output int                     item_count,
	output int                     ok_count,
	output int                     deepest_level,
	output int                     trail_peak
);

	localparam logic [31:0] NO_FRAME = '1;

	typedef struct packed {
		logic [VAL_W-1:0] read_value;
		status_t          status;
	} map_result_t;

	// Shadow state of the block
	logic [VAL_W-1:0] value_mem [TABLE_DEPTH];
	bit               saved_q [TABLE_DEPTH];
	logic [31:0]      trail_q [TRAIL_DEPTH];
	int unsigned      trail_top;
	int unsigned      frame_level;
	logic [31:0]      frame_base;

	map_result_t result_fifo [$];
	int          fails = 0;
	int          accepted = 0;
	int          oks = 0;
	int          level_max = 0;
	int          top_max = 0;

	// Undo the top frame, then rebuild the saved bits from the enclosing one
	task automatic pop_frame(output status_t st);
		int unsigned i;
		int unsigned fb;
		logic [31:0] v;
		if (frame_level == 0 || frame_base == NO_FRAME || frame_base >= trail_top) begin
			st = STAT_PRECOND;
		end else begin
			fb = frame_base;
			i = fb + 1;
			while (i < trail_top) begin
				v = trail_q[i];
				if (v[31]) begin
					v = ~v;
					if (i + 1 < trail_top && v < TABLE_DEPTH)
						value_mem[v] = trail_q[i + 1];
					i += 2;
				end else begin
					if (v < TABLE_DEPTH)
						value_mem[v] = NIL_VALUE;
					i += 1;
				end
			end
			frame_base = trail_q[fb];
			trail_top = fb;
			frame_level--;
			foreach (saved_q[k])
				saved_q[k] = 1'b0;
			if (frame_level != 0 && frame_base != NO_FRAME && frame_base < trail_top) begin
				i = frame_base + 1;
				while (i < trail_top) begin
					v = trail_q[i];
					if (v[31]) begin
						v = ~v;
						i += 2;
					end else begin
						i += 1;
					end
					if (v < TABLE_DEPTH)
						saved_q[v] = 1'b1;
				end
			end
			st = STAT_OK;
		end
	endtask

	// Apply one input item to the shadow state and return its result
	task automatic apply_item(input logic [2:0] op, input logic [KEY_W-1:0] key,
			input logic [VAL_W-1:0] val, output map_result_t r);
		logic [VAL_W-1:0] cur;
		status_t st;
		r.read_value = '0;
		r.status = STAT_OK;
		cur = NIL_VALUE;
		if (op <= OP_REMAP && key >= TABLE_DEPTH) begin
			r.read_value = (op == OP_GET) ? NIL_VALUE : '0;
			r.status = STAT_RANGE;
		end else begin
			if (op <= OP_REMAP)
				cur = value_mem[key];
			case (op)
				OP_GET: begin
					r.read_value = cur;
				end
				OP_SET: begin
					if (!val[31] || val == NIL_VALUE || !cur[31])
						r.status = STAT_PRECOND;
					else
						value_mem[key] = val;
				end
				OP_MAP: begin
					if (val[31] || !cur[31] || (frame_level > 0 && saved_q[key])) begin
						r.status = STAT_PRECOND;
					end else if (frame_level > 0 && trail_top >= TRAIL_DEPTH) begin
						r.status = STAT_FULL;
					end else begin
						value_mem[key] = val;
						if (frame_level > 0) begin
							trail_q[trail_top] = 32'(key);
							trail_top++;
							saved_q[key] = 1'b1;
						end
					end
				end
				OP_REMAP: begin
					if (val[31] || cur[31]) begin
						r.status = STAT_PRECOND;
					end else if (frame_level > 0 && !saved_q[key]) begin
						// first change of this key in the frame: log key and old value
						if (trail_top + 2 > TRAIL_DEPTH) begin
							r.status = STAT_FULL;
						end else begin
							trail_q[trail_top] = ~32'(key);
							trail_q[trail_top + 1] = cur;
							trail_top += 2;
							saved_q[key] = 1'b1;
							value_mem[key] = val;
						end
					end else begin
						value_mem[key] = val;
					end
				end
				OP_PUSH: begin
					if (trail_top >= TRAIL_DEPTH) begin
						r.status = STAT_FULL;
					end else begin
						trail_q[trail_top] = frame_base;
						frame_base = trail_top;
						trail_top++;
						foreach (saved_q[k])
							saved_q[k] = 1'b0;
						frame_level++;
					end
				end
				OP_POP: begin
					pop_frame(st);
					r.status = st;
				end
				default: begin
					r.status = STAT_PRECOND;
				end
			endcase
		end
	endtask

	// Compare results first, then predict for the accepted input item
	always @(posedge clk or negedge arst_n) begin
		map_result_t exp_res;
		map_result_t new_res;
		if (!arst_n) begin
			for (int k = 0; k < TABLE_DEPTH; k++) begin
				value_mem[k] = NIL_VALUE;
				saved_q[k] = 1'b0;
			end
			trail_top = 0;
			frame_base = NO_FRAME;
			frame_level = 0;
			result_fifo.delete();
			pending <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (result_fifo.size() == 0) begin
					fails++;
					$error("result item with nothing expected: read_value %h, status %0d",
						m_tdata[VAL_W-1:0], m_tdata[VAL_W +: 2]);
				end else begin
					exp_res = result_fifo.pop_front();
					if (m_tdata[VAL_W-1:0] !== exp_res.read_value) begin
						fails++;
						$error("read_value: expected %h, actual %h",
							exp_res.read_value, m_tdata[VAL_W-1:0]);
					end
					if (m_tdata[VAL_W +: 2] !== exp_res.status) begin
						fails++;
						$error("status: expected %0d, actual %0d",
							exp_res.status, m_tdata[VAL_W +: 2]);
					end
				end
			end
			if (s_tvalid && s_tready) begin
				apply_item(s_tdata[2:0], s_tdata[3 +: KEY_W], s_tdata[3 + KEY_W +: VAL_W],
					new_res);
				result_fifo.push_back(new_res);
				accepted++;
				if (new_res.status == STAT_OK)
					oks++;
				if (int'(frame_level) > level_max)
					level_max = frame_level;
				if (int'(trail_top) > top_max)
					top_max = trail_top;
			end
			fail_count <= fails;
			pending <= result_fifo.size();
			item_count <= accepted;
			ok_count <= oks;
			deepest_level <= level_max;
			trail_peak <= top_max;
		end
	end

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// Testbench top for backtrackable_index_map_unit: clock, reset, stimulus,
// output back-pressure and verdict. Depends on bim_pkg and bim_checker.
module tb_top;
	import bim_pkg::*;

	localparam int TABLE_DEPTH  = 1024;
	localparam int TRAIL_DEPTH  = 4096;
	localparam int RANDOM_ITEMS = 860;
	localparam int MAX_FRAMES   = 6;
	localparam int TAIL_CYCLES  = 20;
	localparam int CYCLE_LIMIT  = 3_000_000;

	// Opcodes the block does not know
	localparam logic [2:0] OP_UNDEF_A = 3'd6;
	localparam logic [2:0] OP_UNDEF_B = 3'd7;

	logic                   clk;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	// [2:0] opcode, [12:3] key, [44:13] new_value, [47:45] zero
	logic [IN_TDATA_W-1:0]  s_tdata = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	// [31:0] read_value, [33:32] status, [39:34] zero
	logic [OUT_TDATA_W-1:0] m_tdata;

	int fail_count;
	int pending;
	int item_count;
	int ok_count;
	int deepest_level;
	int trail_peak;

	bit          calm = 1'b0;
	int          ready_hold = 0;
	int          open_frames = 0;
	int unsigned cycle_cnt = 0;

	backtrackable_index_map_unit #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.TRAIL_DEPTH(TRAIL_DEPTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	bim_checker #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.TRAIL_DEPTH(TRAIL_DEPTH)
	) chk (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.fail_count(fail_count),
		.pending(pending),
		.item_count(item_count),
		.ok_count(ok_count),
		.deepest_level(deepest_level),
		.trail_peak(trail_peak)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles with %0d results outstanding",
				cycle_cnt, pending);
			$display("== FAIL ==");
			$finish;
		end
	end

	// Output back-pressure: mostly ready, short stalls, a few long ones
	always @(posedge clk) begin
		if (ready_hold > 0) begin
			ready_hold <= ready_hold - 1;
		end else if (calm || $urandom_range(0, 3) != 0) begin
			m_tready <= 1'b1;
			ready_hold <= $urandom_range(0, 5);
		end else begin
			m_tready <= 1'b0;
			ready_hold <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
				: $urandom_range(0, 2);
		end
	end

	// Idle cycles ahead of an input item
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 55)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(10, 30);
	endfunction

	// Value for map or remap: mostly small, some wide, a few negative
	function automatic logic [VAL_W-1:0] mapped_value();
		int s;
		s = $urandom_range(0, 19);
		if (s == 0)
			return $urandom() | 32'h8000_0000;
		if (s < 12)
			return $urandom_range(0, 255);
		return $urandom() & 32'h7FFF_FFFF;
	endfunction

	// Present one item and hold it until accepted; tvalid stays high afterwards
	task automatic send_item(input logic [2:0] op, input logic [KEY_W-1:0] key,
			input logic [VAL_W-1:0] val);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {3'b000, val, key, op};
		do @(posedge clk); while (!s_tready);
	endtask

	// Stop sending and wait for every outstanding result
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	initial begin
		logic [2:0]       op;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] val;
		int               r;
		int               s;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: field extremes, each opcode and the rejection cases
		send_item(OP_GET, 10'd0, '0);
		send_item(OP_GET, 10'h3FF, '1);
		send_item(OP_SET, 10'd5, 32'hFFFF_FFFE);
		send_item(OP_SET, 10'd5, NIL_VALUE);               // nil is not a mark
		send_item(OP_SET, 10'd6, 32'd3);                   // non-negative mark
		send_item(OP_MAP, 10'd5, 32'd0);                   // map over a mark
		send_item(OP_MAP, 10'd5, 32'd7);                   // already mapped
		send_item(OP_MAP, 10'd7, 32'h8000_0000);           // negative value
		send_item(OP_REMAP, 10'd5, 32'h7FFF_FFFF);
		send_item(OP_REMAP, 10'd8, 32'd1);                 // remap of unmapped key
		send_item(OP_REMAP, 10'd5, 32'hFFFF_FFFD);         // negative value
		send_item(OP_SET, 10'd5, 32'h8000_0000);           // mark over mapped key
		send_item(OP_POP, 10'd0, '0);                      // pop with no frame
		send_item(OP_UNDEF_B, 10'h3FF, '1);
		send_item(OP_UNDEF_A, 10'd0, '0);
		// Nested frames: logged and unlogged changes, then undo
		send_item(OP_PUSH, 10'd0, '0);
		send_item(OP_MAP, 10'd9, 32'd1);
		send_item(OP_REMAP, 10'd9, 32'd2);                 // saved already, no log
		send_item(OP_REMAP, 10'd5, 32'd3);
		send_item(OP_MAP, 10'h3FF, 32'h7FFF_FFFF);
		send_item(OP_PUSH, 10'd0, '0);
		send_item(OP_REMAP, 10'd5, 32'd4);
		send_item(OP_POP, 10'd0, '0);
		send_item(OP_GET, 10'd5, '0);
		send_item(OP_POP, 10'd0, '0);
		send_item(OP_GET, 10'd9, '0);
		send_item(OP_GET, 10'h3FF, '0);

		// Random: mostly valid ops on a small key pool inside nested frames
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 64 == 0)
				calm <= ($urandom_range(0, 3) == 0);
			if (n == RANDOM_ITEMS / 2)
				drain();
			if ($urandom_range(0, 3) != 0)
				key = KEY_W'($urandom_range(0, 15));
			else
				key = KEY_W'($urandom_range(0, 1023));
			val = $urandom();
			r = $urandom_range(0, 99);
			if (r < 14) begin
				op = OP_GET;
			end else if (r < 26) begin
				op = OP_SET;
				s = $urandom_range(0, 19);
				if (s == 0)
					val = NIL_VALUE;
				else if (s == 1)
					val = val & 32'h7FFF_FFFF;
				else begin
					val = val | 32'h8000_0000;
					if (val == NIL_VALUE)
						val = 32'hFFFF_FFFE;
				end
			end else if (r < 50) begin
				op = OP_MAP;
				val = mapped_value();
			end else if (r < 68) begin
				op = OP_REMAP;
				val = mapped_value();
			end else if (r < 80 && open_frames < MAX_FRAMES) begin
				op = OP_PUSH;
			end else if (r < 95 && open_frames > 0) begin
				op = OP_POP;
			end else if (r < 95) begin
				op = OP_GET;
			end else if (r < 97) begin
				op = $urandom_range(0, 1) ? OP_UNDEF_A : OP_UNDEF_B;
			end else begin
				op = OP_POP;                                 // may hit level zero
			end
			send_item(op, key, val);
			if (op == OP_PUSH)
				open_frames++;
			else if (op == OP_POP && open_frames > 0)
				open_frames--;
		end

		// Close every open frame so the trail is empty again
		calm <= 1'b0;
		while (open_frames > 0) begin
			send_item(OP_POP, KEY_W'($urandom_range(0, 1023)), $urandom());
			open_frames--;
		end
		send_item(OP_POP, 10'd0, '0);                      // level zero again

		// Let everything come out, then watch a little longer for strays
		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Checked %0d items: %0d accepted as ok, the rest rejected by status.",
			item_count, ok_count);
		$display("Frames nested %0d deep; undo trail reached %0d of %0d entries.",
			deepest_level, trail_peak, TRAIL_DEPTH);
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
